/* design/psr_pkg.sv */
// ---------------------------------------------------------------------------
// psr_pkg: shared types and codes for the procedure symbol record parser
// Event kinds, failure codes and the classified byte passed from front to back.
// ---------------------------------------------------------------------------
`default_nettype none

package psr_pkg;

    // Event kinds on the result channel
    typedef enum logic [2:0] {
        EV_PNAME_BYTE = 3'd0,
        EV_PNAME_END  = 3'd1,
        EV_ANAME_BYTE = 3'd2,
        EV_OFFSET     = 3'd3,
        EV_PROC_DONE  = 3'd4,
        EV_SUCCESS    = 3'd5,
        EV_FAILURE    = 3'd6
    } event_kind_t;

    // Failure codes, meaningful with EV_FAILURE only
    typedef enum logic [1:0] {
        FC_PNAME = 2'd0,
        FC_ANAME = 2'd1,
        FC_TERM  = 2'd2
    } fail_code_t;

    // Terminator byte closing each procedure entry
    localparam logic [7:0] TERM_BYTE = 8'hFF;

    // Queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // One classified record byte
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_zero;
        logic       is_term;
    } psr_item_t;

endpackage

`default_nettype wire

/* design/psr_if.sv */
// ---------------------------------------------------------------------------
// psr_if: valid/ready channels for record bytes and parser events
// One interface per channel, each with a source and a sink modport.
// ---------------------------------------------------------------------------
`default_nettype none

interface psr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_record;

    modport source (output valid, output data_byte, output end_of_record, input ready);
    modport sink   (input valid, input data_byte, input end_of_record, output ready);
endinterface

interface psr_event_if;
    logic               valid;
    logic               ready;
    logic [2:0]         event_kind;
    logic signed [15:0] event_value;
    logic [1:0]         fail_code;

    modport source (output valid, output event_kind, output event_value, output fail_code,
                    input ready);
    modport sink   (input valid, input event_kind, input event_value, input fail_code,
                    output ready);
endinterface

`default_nettype wire

/* design/psr_front.sv */
// ---------------------------------------------------------------------------
// psr_front: input side of the parser
// Accepts record bytes while the queue has room and tags each byte as zero
// or terminator so the back end checks those cases on flags.
// ---------------------------------------------------------------------------
`default_nettype none

module psr_front (
    psr_byte_if.sink         byte_in,
    input  wire logic        q_full,
    output psr_pkg::psr_item_t q_item,
    output logic             q_push
);

    // Ready whenever the queue can take one more entry
    assign byte_in.ready = !q_full;
    assign q_push        = byte_in.valid && !q_full;

    // Classify the byte
    always_comb
    begin
        q_item.data    = byte_in.data_byte;
        q_item.last    = byte_in.end_of_record;
        q_item.is_zero = (byte_in.data_byte == 8'd0);
        q_item.is_term = (byte_in.data_byte == psr_pkg::TERM_BYTE);
    end

endmodule

`default_nettype wire

/* design/psr_queue.sv */
// ---------------------------------------------------------------------------
// psr_queue: short FIFO between front and back
// Two register entries; push and pop may happen in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module psr_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire psr_pkg::psr_item_t push_item,
    input  wire logic               pop,
    output psr_pkg::psr_item_t      head_item,
    output logic                    not_empty,
    output logic                    full
);

    localparam int PTR_W = $clog2(psr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(psr_pkg::QUEUE_DEPTH + 1);

    psr_pkg::psr_item_t entry_reg [psr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(psr_pkg::QUEUE_DEPTH));
    assign head_item = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(psr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(psr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* design/psr_back.sv */
// ---------------------------------------------------------------------------
// psr_back: record parsing state machine and event output register
// Takes one classified byte per cycle from the queue while its output register
// is free or draining, advances the parse state and loads at most one event.
// ---------------------------------------------------------------------------
`default_nettype none

module psr_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire psr_pkg::psr_item_t q_item,
    input  wire logic               q_not_empty,
    output logic                    q_pop,
    psr_event_if.source             event_out
);

    typedef enum logic [2:0] {
        PH_CNT_LO,
        PH_CNT_HI,
        PH_PNAME,
        PH_PCOUNT,
        PH_ANAME,
        PH_OFF_LO,
        PH_OFF_HI,
        PH_TERM
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [15:0]          procs_left_reg, procs_left_next;
    logic [7:0]           params_left_reg, params_left_next;
    logic [7:0]           low_hold_reg, low_hold_next;
    logic                 finished_reg, finished_next;

    logic                 out_valid_reg, out_valid_next;
    psr_pkg::event_kind_t kind_reg, kind_next;
    logic signed [15:0]   value_reg, value_next;
    psr_pkg::fail_code_t  code_reg, code_next;

    // Event produced by the byte at the queue head
    logic                 emit;
    psr_pkg::event_kind_t emit_kind;
    logic [15:0]          emit_value;
    psr_pkg::fail_code_t  emit_code;

    logic [15:0]          count_word;
    logic [15:0]          procs_dec;
    logic [7:0]           params_dec;

    // Take a byte when the output slot is free or is draining now
    assign q_pop = q_not_empty && (!out_valid_reg || event_out.ready);

    assign count_word = {q_item.data, low_hold_reg};
    assign procs_dec  = procs_left_reg - 16'd1;
    assign params_dec = params_left_reg - 8'd1;

    // Parse step
    always_comb
    begin
        phase_next       = phase_reg;
        procs_left_next  = procs_left_reg;
        params_left_next = params_left_reg;
        low_hold_next    = low_hold_reg;
        finished_next    = finished_reg;
        emit             = 1'b0;
        emit_kind        = psr_pkg::EV_PNAME_BYTE;
        emit_value       = 16'd0;
        emit_code        = psr_pkg::FC_PNAME;

        if (q_pop && !finished_reg)
        begin
            unique case (phase_reg)
                PH_CNT_LO:
                begin
                    low_hold_next = q_item.data;
                    if (q_item.last)
                    begin
                        emit      = 1'b1;
                        emit_kind = psr_pkg::EV_SUCCESS;
                    end
                    else
                    begin
                        phase_next = PH_CNT_HI;
                    end
                end
                PH_CNT_HI:
                begin
                    procs_left_next = count_word;
                    if (count_word == 16'd0)
                    begin
                        emit      = 1'b1;
                        emit_kind = psr_pkg::EV_SUCCESS;
                    end
                    else if (q_item.last)
                    begin
                        emit      = 1'b1;
                        emit_kind = psr_pkg::EV_FAILURE;
                        emit_code = psr_pkg::FC_PNAME;
                    end
                    else
                    begin
                        phase_next = PH_PNAME;
                    end
                end
                PH_PNAME:
                begin
                    if (q_item.is_zero)
                    begin
                        if (q_item.last)
                        begin
                            emit      = 1'b1;
                            emit_kind = psr_pkg::EV_FAILURE;
                            emit_code = psr_pkg::FC_TERM;
                        end
                        else
                        begin
                            phase_next = PH_PCOUNT;
                        end
                    end
                    else if (q_item.last)
                    begin
                        emit      = 1'b1;
                        emit_kind = psr_pkg::EV_FAILURE;
                        emit_code = psr_pkg::FC_PNAME;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        emit_kind  = psr_pkg::EV_PNAME_BYTE;
                        emit_value = {8'd0, q_item.data};
                    end
                end
                PH_PCOUNT:
                begin
                    params_left_next = q_item.data;
                    emit             = 1'b1;
                    if (q_item.last)
                    begin
                        emit_kind = psr_pkg::EV_FAILURE;
                        emit_code = q_item.is_zero ? psr_pkg::FC_TERM : psr_pkg::FC_ANAME;
                    end
                    else
                    begin
                        phase_next = q_item.is_zero ? PH_TERM : PH_ANAME;
                        emit_kind  = psr_pkg::EV_PNAME_END;
                        emit_value = {8'd0, q_item.data};
                    end
                end
                PH_ANAME:
                begin
                    if (q_item.is_zero)
                    begin
                        if (q_item.last)
                        begin
                            emit      = 1'b1;
                            emit_kind = psr_pkg::EV_FAILURE;
                            emit_code = (params_left_reg != 8'd1) ? psr_pkg::FC_ANAME
                                                                  : psr_pkg::FC_TERM;
                        end
                        else
                        begin
                            phase_next = PH_OFF_LO;
                        end
                    end
                    else if (q_item.last)
                    begin
                        emit      = 1'b1;
                        emit_kind = psr_pkg::EV_FAILURE;
                        emit_code = psr_pkg::FC_ANAME;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        emit_kind  = psr_pkg::EV_ANAME_BYTE;
                        emit_value = {8'd0, q_item.data};
                    end
                end
                PH_OFF_LO:
                begin
                    low_hold_next = q_item.data;
                    if (q_item.last)
                    begin
                        // Lone low byte: reread as next name byte or terminator
                        emit = 1'b1;
                        if (params_left_reg != 8'd1)
                        begin
                            emit_kind = psr_pkg::EV_FAILURE;
                            if (!q_item.is_zero)
                            begin
                                emit_code = psr_pkg::FC_ANAME;
                            end
                            else
                            begin
                                emit_code = (params_left_reg != 8'd2) ? psr_pkg::FC_ANAME
                                                                      : psr_pkg::FC_TERM;
                            end
                        end
                        else if (!q_item.is_term)
                        begin
                            emit_kind = psr_pkg::EV_FAILURE;
                            emit_code = psr_pkg::FC_TERM;
                        end
                        else if (procs_left_reg <= 16'd1)
                        begin
                            emit_kind = psr_pkg::EV_SUCCESS;
                        end
                        else
                        begin
                            emit_kind = psr_pkg::EV_FAILURE;
                            emit_code = psr_pkg::FC_PNAME;
                        end
                    end
                    else
                    begin
                        phase_next = PH_OFF_HI;
                    end
                end
                PH_OFF_HI:
                begin
                    params_left_next = params_dec;
                    emit             = 1'b1;
                    if (q_item.last)
                    begin
                        emit_kind = psr_pkg::EV_FAILURE;
                        emit_code = (params_dec != 8'd0) ? psr_pkg::FC_ANAME
                                                         : psr_pkg::FC_TERM;
                    end
                    else
                    begin
                        phase_next = (params_dec != 8'd0) ? PH_ANAME : PH_TERM;
                        emit_kind  = psr_pkg::EV_OFFSET;
                        emit_value = {q_item.data, low_hold_reg};
                    end
                end
                PH_TERM:
                begin
                    emit = 1'b1;
                    if (!q_item.is_term)
                    begin
                        emit_kind = psr_pkg::EV_FAILURE;
                        emit_code = psr_pkg::FC_TERM;
                    end
                    else
                    begin
                        procs_left_next = procs_dec;
                        if (procs_dec == 16'd0)
                        begin
                            emit_kind = psr_pkg::EV_SUCCESS;
                        end
                        else if (q_item.last)
                        begin
                            emit_kind = psr_pkg::EV_FAILURE;
                            emit_code = psr_pkg::FC_PNAME;
                        end
                        else
                        begin
                            phase_next = PH_PNAME;
                            emit_kind  = psr_pkg::EV_PROC_DONE;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_CNT_LO;
                end
            endcase

            // Any verdict closes the record until its last byte
            if (emit && (emit_kind == psr_pkg::EV_SUCCESS || emit_kind == psr_pkg::EV_FAILURE))
            begin
                finished_next = 1'b1;
            end
        end

        // Record boundary returns to the reset state
        if (q_pop && q_item.last)
        begin
            phase_next       = PH_CNT_LO;
            procs_left_next  = 16'd0;
            params_left_next = 8'd0;
            low_hold_next    = 8'd0;
            finished_next    = 1'b0;
        end
    end

    // Output register load
    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        code_next      = code_reg;
        if (q_pop)
        begin
            out_valid_next = emit;
            kind_next      = emit_kind;
            value_next     = $signed(emit_value);
            code_next      = (emit_kind == psr_pkg::EV_FAILURE) ? emit_code : psr_pkg::FC_PNAME;
        end
        else if (event_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_CNT_LO;
            procs_left_reg  <= 16'd0;
            params_left_reg <= 8'd0;
            low_hold_reg    <= 8'd0;
            finished_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            kind_reg        <= psr_pkg::EV_PNAME_BYTE;
            value_reg       <= 16'sd0;
            code_reg        <= psr_pkg::FC_PNAME;
        end
        else
        begin
            phase_reg       <= phase_next;
            procs_left_reg  <= procs_left_next;
            params_left_reg <= params_left_next;
            low_hold_reg    <= low_hold_next;
            finished_reg    <= finished_next;
            out_valid_reg   <= out_valid_next;
            kind_reg        <= kind_next;
            value_reg       <= value_next;
            code_reg        <= code_next;
        end
    end

    assign event_out.valid       = out_valid_reg;
    assign event_out.event_kind  = kind_reg;
    assign event_out.event_value = value_reg;
    assign event_out.fail_code   = code_reg;

endmodule

`default_nettype wire

/* design/procedure_symbol_record_parser.sv */
// ---------------------------------------------------------------------------
// procedure_symbol_record_parser: streaming parser for procedure symbol records
//
// byte_in carries one record byte per transfer with end_of_record on the
// final byte. event_out carries at most one event per byte: name bytes, the
// name end with its parameter count, signed frame offsets, procedure done,
// and a final success or failure verdict with a failure code. Bytes after a
// verdict are dropped until end_of_record; the byte after end_of_record
// starts a new record.
// Throughput: one byte per cycle while the output register is free or draining,
// set by the single-step parse state machine. Events are registered: a byte
// is written into the two-entry queue when it transfers, and the parse stage
// then loads its event into the output register.
// When event_out stalls, the parse stage holds and the queue fills; byte_in
// drops ready once the queue holds two bytes. While an event waits in the output
// register no byte is parsed, including bytes that produce no event.
// Reset clears the queue, the parse state and the output valid.
// ---------------------------------------------------------------------------
`default_nettype none

module procedure_symbol_record_parser (
    input  wire logic   clk,
    input  wire logic   rst_n,
    psr_byte_if.sink    byte_in,
    psr_event_if.source event_out
);

    psr_pkg::psr_item_t push_item;
    psr_pkg::psr_item_t head_item;
    logic               push;
    logic               pop;
    logic               full;
    logic               not_empty;

    // Front: accept and classify
    psr_front u_front (
        .byte_in (byte_in),
        .q_full  (full),
        .q_item  (push_item),
        .q_push  (push)
    );

    // Decoupling queue
    psr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .not_empty (not_empty),
        .full      (full)
    );

    // Back: parse and emit
    psr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_item      (head_item),
        .q_not_empty (not_empty),
        .q_pop       (pop),
        .event_out   (event_out)
    );

endmodule

`default_nettype wire

/* tb/procedure_symbol_record_parser_test.sv */
// ---------------------------------------------------------------------------
// procedure_symbol_record_parser_test: self-checking bench for the record parser
// Streams symbol records byte by byte with random gaps on the byte channel and
// random stalls on the event channel. A behavioral parser in the bench predicts
// the event, if any, of every accepted byte, and each event that comes out is
// compared with the oldest prediction. About half of the records are kept whole
// with random content; the rest are cut short, carry trailing bytes or are noise.
// ---------------------------------------------------------------------------

module procedure_symbol_record_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Parse position within a record
    typedef enum logic [2:0] {
        ST_COUNT_LO,
        ST_COUNT_HI,
        ST_PROC_NAME,
        ST_PARAM_COUNT,
        ST_PARAM_NAME,
        ST_OFFSET_LO,
        ST_OFFSET_HI,
        ST_TERMINATOR
    } parse_phase_t;

    typedef struct packed {
        psr_pkg::event_kind_t kind;
        logic [15:0]          value;
        psr_pkg::fail_code_t  code;
    } rec_event_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rec_byte_t;

    // The code field reads zero on every event but a failure
    localparam psr_pkg::fail_code_t NO_FAIL = psr_pkg::FC_PNAME;

    localparam int SIDE_SEND = 0;
    localparam int SIDE_RECV = 1;
    localparam int RANDOM_BYTES = 500;
    localparam int DIRECTED_LEN = 24;
    localparam int SETTLE_CYCLES = 20;

    logic clk;
    logic rst_n;

    psr_byte_if  byte_ch ();
    psr_event_if event_ch ();

    procedure_symbol_record_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_ch),
        .event_out (event_ch)
    );

    // Stimulus and scoreboard storage
    rec_byte_t  pending_bytes[$];
    rec_event_t expected_events[$];
    logic [7:0] rec_bytes[$];
    logic [8:0] directed_bytes [0:DIRECTED_LEN-1];

    int calm_left [0:1];
    int send_gap;
    int recv_stall;
    int error_count;
    int bytes_sent;
    int records_sent;
    int events_checked;

    rec_byte_t  next_byte;
    rec_event_t oldest_event;

    // Predictor state
    parse_phase_t rec_phase;
    logic [15:0]  procs_remaining;
    logic [7:0]   params_remaining;
    logic [7:0]   offset_low;
    logic         verdict_given;

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------
    function automatic void clear_parse_state();
        rec_phase        = ST_COUNT_LO;
        procs_remaining  = '0;
        params_remaining = '0;
        offset_low       = '0;
        verdict_given    = 1'b0;
    endfunction

    function automatic rec_event_t make_event(psr_pkg::event_kind_t kind, logic [15:0] value,
                                              psr_pkg::fail_code_t code);
        rec_event_t e;
        e.kind  = kind;
        e.value = value;
        e.code  = code;
        return e;
    endfunction

    function automatic rec_event_t give_verdict(bit ok, psr_pkg::fail_code_t code);
        verdict_given = 1'b1;
        return ok ? make_event(psr_pkg::EV_SUCCESS, '0, NO_FAIL)
                  : make_event(psr_pkg::EV_FAILURE, '0, code);
    endfunction

    // Advances the parse by one byte; returns 1 when the byte yields an event
    function automatic bit parse_event(input logic [7:0] b, input bit last,
                                       output rec_event_t ev);
        bit hit;
        int rest;
        hit = 1'b1;
        ev  = make_event(psr_pkg::EV_SUCCESS, '0, NO_FAIL);
        if (verdict_given)
            return 1'b0;
        case (rec_phase)
            ST_COUNT_LO:
            begin
                offset_low = b;
                hit = last;
                if (last)
                    ev = give_verdict(1'b1, NO_FAIL);
                else
                    rec_phase = ST_COUNT_HI;
            end
            ST_COUNT_HI:
            begin
                procs_remaining = {b, offset_low};
                if (procs_remaining == 16'd0)
                    ev = give_verdict(1'b1, NO_FAIL);
                else if (last)
                    ev = give_verdict(1'b0, psr_pkg::FC_PNAME);
                else
                begin
                    rec_phase = ST_PROC_NAME;
                    hit = 1'b0;
                end
            end
            ST_PROC_NAME:
            begin
                if (b == 8'd0)
                begin
                    // name end is reported on the count byte, not on the zero
                    if (last)
                        ev = give_verdict(1'b0, psr_pkg::FC_TERM);
                    else
                    begin
                        rec_phase = ST_PARAM_COUNT;
                        hit = 1'b0;
                    end
                end
                else if (last)
                    ev = give_verdict(1'b0, psr_pkg::FC_PNAME);
                else
                    ev = make_event(psr_pkg::EV_PNAME_BYTE, {8'h00, b}, NO_FAIL);
            end
            ST_PARAM_COUNT:
            begin
                params_remaining = b;
                if (last)
                    ev = give_verdict(1'b0,
                        (b == 8'd0) ? psr_pkg::FC_TERM : psr_pkg::FC_ANAME);
                else
                begin
                    rec_phase = (b == 8'd0) ? ST_TERMINATOR : ST_PARAM_NAME;
                    ev = make_event(psr_pkg::EV_PNAME_END, {8'h00, b}, NO_FAIL);
                end
            end
            ST_PARAM_NAME:
            begin
                if (b == 8'd0)
                begin
                    if (last)
                    begin
                        rest = int'(params_remaining) - 1;
                        ev = give_verdict(1'b0,
                            (rest != 0) ? psr_pkg::FC_ANAME : psr_pkg::FC_TERM);
                    end
                    else
                    begin
                        rec_phase = ST_OFFSET_LO;
                        hit = 1'b0;
                    end
                end
                else if (last)
                    ev = give_verdict(1'b0, psr_pkg::FC_ANAME);
                else
                    ev = make_event(psr_pkg::EV_ANAME_BYTE, {8'h00, b}, NO_FAIL);
            end
            ST_OFFSET_LO:
            begin
                offset_low = b;
                hit = last;
                if (!last)
                    rec_phase = ST_OFFSET_HI;
                // missing high byte reads as zero; the low byte is re-read
                // as the next name byte or as the terminator
                else if (params_remaining != 8'd1)
                    ev = give_verdict(1'b0,
                        (b != 8'd0 || params_remaining != 8'd2) ? psr_pkg::FC_ANAME
                                                                : psr_pkg::FC_TERM);
                else if (b != psr_pkg::TERM_BYTE)
                    ev = give_verdict(1'b0, psr_pkg::FC_TERM);
                else if (procs_remaining <= 16'd1)
                    ev = give_verdict(1'b1, NO_FAIL);
                else
                    ev = give_verdict(1'b0, psr_pkg::FC_PNAME);
            end
            ST_OFFSET_HI:
            begin
                params_remaining = params_remaining - 8'd1;
                if (last)
                    ev = give_verdict(1'b0, (params_remaining != 8'd0) ? psr_pkg::FC_ANAME
                                                                        : psr_pkg::FC_TERM);
                else
                begin
                    rec_phase = (params_remaining != 8'd0) ? ST_PARAM_NAME : ST_TERMINATOR;
                    ev = make_event(psr_pkg::EV_OFFSET, {b, offset_low}, NO_FAIL);
                end
            end
            ST_TERMINATOR:
            begin
                if (b != psr_pkg::TERM_BYTE)
                    ev = give_verdict(1'b0, psr_pkg::FC_TERM);
                else
                begin
                    procs_remaining = procs_remaining - 16'd1;
                    // the last procedure closes with the verdict itself
                    if (procs_remaining == 16'd0)
                        ev = give_verdict(1'b1, NO_FAIL);
                    else if (last)
                        ev = give_verdict(1'b0, psr_pkg::FC_PNAME);
                    else
                    begin
                        rec_phase = ST_PROC_NAME;
                        ev = make_event(psr_pkg::EV_PROC_DONE, '0, NO_FAIL);
                    end
                end
            end
            default:
            begin
                rec_phase = ST_COUNT_LO;
                hit = 1'b0;
            end
        endcase
        return hit;
    endfunction

    function automatic void predict_byte(logic [7:0] b, bit last);
        rec_event_t ev;
        if (parse_event(b, last, ev))
            expected_events.insert(expected_events.size(), ev);
        if (last)
            clear_parse_state();
    endfunction

    // -----------------------------------------------------------------------
    // Helpers
    // -----------------------------------------------------------------------
    // Mostly short gaps, a few long ones, and now and then a calm stretch
    function automatic int pick_gap(int side);
        int r;
        if (calm_left[side] > 0)
        begin
            calm_left[side] = calm_left[side] - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left[side] = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(16, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 30)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    function automatic void queue_record();
        rec_byte_t rb;
        for (int i = 0; i < rec_bytes.size(); i++)
        begin
            rb.data = rec_bytes[i];
            rb.last = (i == rec_bytes.size() - 1);
            pending_bytes.insert(pending_bytes.size(), rb);
        end
    endfunction

    function automatic void add_name(int max_len);
        int len;
        len = $urandom_range(0, max_len);
        for (int i = 0; i < len; i++)
            rec_bytes.insert(rec_bytes.size(), 8'($urandom_range(1, 255)));
        rec_bytes.insert(rec_bytes.size(), 8'h00);
    endfunction

    // Builds one random record into rec_bytes
    function automatic void build_record();
        int mode;
        int nprocs;
        int nparams;
        int cut;
        int off_lo_at[$];
        logic [15:0] declared;
        logic [15:0] off;
        logic [7:0]  term;
        rec_bytes.delete();
        off_lo_at.delete();
        mode = $urandom_range(0, 99);
        if (mode < 6)
        begin
            // plain noise
            repeat ($urandom_range(1, 8))
                rec_bytes.insert(rec_bytes.size(), 8'($urandom));
            return;
        end
        nprocs = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
        declared = 16'(nprocs);
        if ($urandom_range(0, 9) == 0)
            declared = 16'($urandom);
        rec_bytes.insert(rec_bytes.size(), declared[7:0]);
        rec_bytes.insert(rec_bytes.size(), declared[15:8]);
        for (int p = 0; p < nprocs; p++)
        begin
            add_name(3);
            nparams = $urandom_range(0, 3);
            rec_bytes.insert(rec_bytes.size(), 8'(nparams));
            for (int a = 0; a < nparams; a++)
            begin
                add_name(2);
                case ($urandom_range(0, 7))
                    0: off = 16'h8000;
                    1: off = 16'h7FFF;
                    2: off = 16'hFFFF;
                    3: off = 16'h00FF;
                    default: off = 16'($urandom);
                endcase
                off_lo_at.insert(off_lo_at.size(), rec_bytes.size());
                rec_bytes.insert(rec_bytes.size(), off[7:0]);
                rec_bytes.insert(rec_bytes.size(), off[15:8]);
            end
            term = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 254))
                                                : psr_pkg::TERM_BYTE;
            rec_bytes.insert(rec_bytes.size(), term);
        end
        if (mode < 40)
        begin
            // cut short, often right after an offset low byte
            if (off_lo_at.size() > 0 && $urandom_range(0, 2) == 0)
            begin
                cut = off_lo_at[$urandom_range(0, off_lo_at.size() - 1)];
                case ($urandom_range(0, 2))
                    0: rec_bytes[cut] = 8'h00;
                    1: rec_bytes[cut] = psr_pkg::TERM_BYTE;
                    default: ;
                endcase
            end
            else
                cut = $urandom_range(0, rec_bytes.size() - 1);
            while (rec_bytes.size() > cut + 1)
                void'(rec_bytes.pop_back());
        end
        else if (mode < 52)
        begin
            // bytes past the verdict
            repeat ($urandom_range(1, 5))
                rec_bytes.insert(rec_bytes.size(), 8'($urandom));
        end
    endfunction

    // -----------------------------------------------------------------------
    // Clock and reset
    // -----------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.end_of_record = 1'b0;
        event_ch.ready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // -----------------------------------------------------------------------
    // Byte driver: predicts on each transfer, then loads the next byte
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_ch.valid <= 1'b0;
            byte_ch.data_byte <= 8'h00;
            byte_ch.end_of_record <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                predict_byte(byte_ch.data_byte, byte_ch.end_of_record);
                bytes_sent++;
                if (byte_ch.end_of_record)
                    records_sent++;
            end
            if (!byte_ch.valid || byte_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    byte_ch.valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    next_byte = pending_bytes.pop_front();
                    byte_ch.valid <= 1'b1;
                    byte_ch.data_byte <= next_byte.data;
                    byte_ch.end_of_record <= next_byte.last;
                    send_gap <= pick_gap(SIDE_SEND);
                end
                else
                    byte_ch.valid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Event receiver: random back-pressure
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_ch.ready <= 1'b0;
            recv_stall <= 0;
        end
        else if (recv_stall > 0)
        begin
            recv_stall <= recv_stall - 1;
            event_ch.ready <= 1'b0;
        end
        else
        begin
            event_ch.ready <= 1'b1;
            recv_stall <= pick_gap(SIDE_RECV);
        end
    end

    // -----------------------------------------------------------------------
    // Event checker
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && event_ch.valid && event_ch.ready)
        begin
            if (expected_events.size() == 0)
                report_mismatch($sformatf("unexpected event kind %0d value %0d code %0d",
                    event_ch.event_kind, event_ch.event_value, event_ch.fail_code));
            else
            begin
                oldest_event = expected_events.pop_front();
                events_checked++;
                if (event_ch.event_kind !== oldest_event.kind ||
                    event_ch.event_value !== oldest_event.value ||
                    event_ch.fail_code !== oldest_event.code)
                    report_mismatch($sformatf(
                        "got kind %0d value %0d code %0d, want %s value %0d code %s",
                        event_ch.event_kind, event_ch.event_value, event_ch.fail_code,
                        oldest_event.kind.name(), $signed(oldest_event.value),
                        oldest_event.code.name()));
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus and end of run
    // -----------------------------------------------------------------------
    initial
    begin
        int queued;
        error_count = 0;
        bytes_sent = 0;
        records_sent = 0;
        events_checked = 0;
        calm_left[SIDE_SEND] = 0;
        calm_left[SIDE_RECV] = 0;
        clear_parse_state();

        // {end_of_record, byte}
        directed_bytes = '{
            // one-byte record
            9'h137,
            // zero procedures, then trailing bytes
            9'h000, 9'h000, 9'h0AA, 9'h155,
            // two procedures; the second is unnamed and has no parameters
            9'h002, 9'h000, 9'h041, 9'h000, 9'h001, 9'h0FF, 9'h000,
            9'h000, 9'h080, 9'h0FF, 9'h000, 9'h000, 9'h1FF,
            // bad terminator
            9'h001, 9'h000, 9'h042, 9'h000, 9'h000, 9'h17E
        };
        for (int i = 0; i < DIRECTED_LEN; i++)
        begin
            next_byte.data = directed_bytes[i][7:0];
            next_byte.last = directed_bytes[i][8];
            pending_bytes.insert(pending_bytes.size(), next_byte);
        end

        queued = 0;
        while (queued < RANDOM_BYTES)
        begin
            build_record();
            queue_record();
            queued += rec_bytes.size();
        end

        // drain stimulus, then outstanding events, then let the pipe settle
        @(posedge clk);
        while (pending_bytes.size() > 0 || byte_ch.valid || !rst_n)
            @(posedge clk);
        while (expected_events.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d bytes in %0d records driven, %0d events checked",
                 bytes_sent, records_sent, events_checked);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("timeout with %0d events outstanding", expected_events.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
